[sv/ubh_pkg.sv]
package ubh_pkg;

  localparam int MAX_BINS    = 256;
  localparam int COUNT_WIDTH = 32;

  localparam int BIN_AW   = $clog2(MAX_BINS);
  localparam int USED_W   = $clog2(MAX_BINS + 1);
  localparam int SAMPLE_W = 24;
  localparam int SIZE_W   = 23;
  localparam int NB_W     = 9;
  localparam int IDX_W    = 8;
  localparam int EDGE_W   = 40;
  localparam int OCNT_W   = 32;
  localparam int CFG_DW   = 24;
  localparam int CFG_AW   = 2;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [CFG_AW-1:0] CFG_NUM_BINS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BIN_MIN  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BIN_SIZE = 2'd2;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [NB_W-1:0]   NUM_BINS_RST = 9'd255;
  localparam logic [SIZE_W-1:0] BIN_SIZE_RST = 23'd256;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           read_index;
  } ubh_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         bin_number;
    logic signed [EDGE_W-1:0] lower_edge;
    logic [OCNT_W-1:0]        bin_count;
  } ubh_out_t;

  typedef struct packed {
    logic [NB_W-1:0]            num_bins;
    logic signed [SAMPLE_W-1:0] bin_min;
    logic [SIZE_W-1:0]          bin_size;
  } ubh_cfg_t;

  // one queued job: skip marks a sample below bin_min or a zero bin size
  typedef struct packed {
    logic                action;
    logic                skip;
    logic [SAMPLE_W-1:0] diff;
    logic [IDX_W-1:0]    read_index;
  } ubh_job_t;

endpackage

[sv/uniform_bin_histogram_unit.sv]
// Uniform-bin histogram of signed Q15.8 samples. An item is taken when start is high and busy
// is low; it goes into a four-entry job queue, so items are taken on back-to-back cycles until
// that queue fills, and busy is high only while it is full. The back end drains the queue one
// job at a time: a sample below bin_min, past the last bin or with a zero bin size is only
// popped; a counted sample is popped, then goes through an eight-step restoring divider for
// the bin number, then a read and a write of the count memory; a read-and-clear is popped,
// passes through ST_RDA and ST_RDB, and its result is registered out of ST_RDB onto
// out_valid/out_data for one cycle. The queue keeps taking items, until full, while the back end
// works on a job. The receiver cannot stall; results are never held back. Counts are zero
// right after reset: per-bin valid bits clear at once, no clearing pass. The user must write
// configuration only while no job is queued or in flight; the block itself does not enforce this.
module uniform_bin_histogram_unit import ubh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ubh_in_t           in_data,
  output logic              out_valid,
  output ubh_out_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  ubh_cfg_t cfg_r;
  ubh_job_t push_job;
  ubh_job_t head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_bins <= NUM_BINS_RST;
      cfg_r.bin_min  <= '0;
      cfg_r.bin_size <= BIN_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NUM_BINS: cfg_r.num_bins <= cfg_data[NB_W-1:0];
        CFG_BIN_MIN:  cfg_r.bin_min  <= cfg_data[SAMPLE_W-1:0];
        CFG_BIN_SIZE: cfg_r.bin_size <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ubh_front u_front (
    .cfg    (cfg_r),
    .start  (start),
    .in_data(in_data),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .job    (push_job)
  );

  ubh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  ubh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // a read result needs two back-end states, so strobes never abut
  a_no_back_to_back_results: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid
  ) else $error("result strobe high on consecutive cycles");

  // an accepted transfer is always held in the queue on the next cycle
  a_accept_lands_in_queue: assert property (
    @(posedge clk) disable iff (!rst_n) (start && !busy) |=> !q_empty
  ) else $error("accepted transfer lost before the queue");

  a_pop_only_when_filled: assert property (
    @(posedge clk) disable iff (!rst_n) pop |-> !q_empty
  ) else $error("job popped from an empty queue");

endmodule

[sv/ubh_ram.sv]
module ubh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/ubh_front.sv]
module ubh_front import ubh_pkg::*; (
  input  ubh_cfg_t cfg,
  input  logic     start,
  input  ubh_in_t  in_data,
  input  logic     q_full,
  output logic     busy,
  output logic     push,
  output ubh_job_t job
);

  logic [SAMPLE_W:0] diff;

  assign diff = {in_data.sample[SAMPLE_W-1], in_data.sample}
              - {cfg.bin_min[SAMPLE_W-1], cfg.bin_min};

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    job.action     = in_data.action;
    job.skip       = diff[SAMPLE_W] || (cfg.bin_size == '0);
    job.diff       = diff[SAMPLE_W-1:0];
    job.read_index = in_data.read_index;
  end

endmodule

[sv/ubh_queue.sv]
module ubh_queue import ubh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ubh_job_t push_job,
  input  logic     pop,
  output ubh_job_t head,
  output logic     empty,
  output logic     full
);

  ubh_job_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == (QAW+1)'(QDEPTH));
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/ubh_back.sv]
module ubh_back import ubh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ubh_cfg_t cfg,
  input  ubh_job_t head,
  input  logic     q_empty,
  output logic     pop,
  output logic     out_valid,
  output ubh_out_t out_data
);

  localparam int LW  = USED_W + SIZE_W;
  localparam int DVW = SIZE_W + BIN_AW;
  localparam int SW  = $clog2(BIN_AW + 1);
  localparam int PW  = IDX_W + SIZE_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MRD  = 3'd2;
  localparam logic [2:0] ST_MWR  = 3'd3;
  localparam logic [2:0] ST_RDA  = 3'd4;
  localparam logic [2:0] ST_RDB  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  ubh_job_t               job_r, job_nxt;
  logic [SAMPLE_W-1:0]    rem_r, rem_nxt;
  logic [BIN_AW-1:0]      q_r, q_nxt;
  logic [SW-1:0]          step_r, step_nxt;
  logic [LW-1:0]          limit_r;
  logic [USED_W-1:0]      used;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [MAX_BINS-1:0]    valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ubh_out_t               out_r, out_nxt;

  logic [DVW-1:0]         dvs;
  logic                   q_bit;
  logic [BIN_AW-1:0]      idx_addr;
  logic                   idx_in_range;
  logic [BIN_AW-1:0]      raddr;
  logic                   ram_we;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [EDGE_W-1:0]      edge_sum;

  assign used = (cfg.num_bins > NB_W'(MAX_BINS)) ? USED_W'(MAX_BINS) : USED_W'(cfg.num_bins);

  always_ff @(posedge clk) begin
    limit_r <= LW'(used) * LW'(cfg.bin_size);
  end

  assign idx_addr     = BIN_AW'(job_r.read_index);
  assign idx_in_range = ((IDX_W+1)'(job_r.read_index) < (IDX_W+1)'(MAX_BINS));
  assign raddr        = (state_r == ST_RDA) ? idx_addr : q_r;

  assign dvs   = DVW'(cfg.bin_size) << step_r;
  assign q_bit = (DVW'(rem_r) >= dvs);

  assign edge_sum = {{(EDGE_W-SAMPLE_W){cfg.bin_min[SAMPLE_W-1]}}, cfg.bin_min}
                  + EDGE_W'(prod_r);

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    cur_cnt       = '0;
    ram_wdata     = '0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          job_nxt = head;
          if (head.action == ACT_READ) begin
            state_nxt = ST_RDA;
          end else if (!head.skip && (LW'(head.diff) < limit_r)) begin
            rem_nxt   = head.diff;
            q_nxt     = '0;
            step_nxt  = SW'(BIN_AW - 1);
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (q_bit) begin
          rem_nxt = rem_r - dvs[SAMPLE_W-1:0];
        end
        q_nxt = {q_r[BIN_AW-2:0], q_bit};
        if (step_r == '0) begin
          state_nxt = ST_MRD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_MRD: begin
        state_nxt = ST_MWR;
      end
      ST_MWR: begin
        cur_cnt   = valid_r[q_r] ? ram_rdata : '0;
        ram_wdata = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
        ram_we    = 1'b1;
        valid_nxt[q_r] = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RDA: begin
        prod_nxt  = PW'(job_r.read_index) * PW'(cfg.bin_size);
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        cur_cnt = (idx_in_range && valid_r[idx_addr]) ? ram_rdata : '0;
        if (idx_in_range) begin
          valid_nxt[idx_addr] = 1'b0;
        end
        out_valid_nxt      = 1'b1;
        out_nxt.bin_number = job_r.read_index;
        out_nxt.lower_edge = edge_sum;
        out_nxt.bin_count  = OCNT_W'(cur_cnt);
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  ubh_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(MAX_BINS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_r),
    .wdata(ram_wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ubh_pkg::*;

  localparam int SETTLE  = 64;
  localparam int PHASES  = 12;
  localparam int PER_PHASE = 80;

  typedef struct {
    ubh_in_t  item;
    bit       pinned;
    ubh_out_t want;
  } plan_row_t;

  typedef struct {
    bit       pinned;
    ubh_out_t want;
  } pin_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ubh_in_t           in_data = '0;
  logic              out_valid;
  ubh_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = CFG_NUM_BINS;
  logic [CFG_DW-1:0] cfg_data = '0;

  uniform_bin_histogram_unit dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_addr, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // histogram predictor state
  logic [COUNT_WIDTH-1:0] tally [MAX_BINS] = '{default: '0};
  ubh_cfg_t model_cfg = '{NUM_BINS_RST, '0, BIN_SIZE_RST};
  ubh_out_t due_reports [$];
  pin_t     pinned_reports [$];
  int       errors = 0;

  function automatic void tally_step(input ubh_in_t x, output logic has, output ubh_out_t r);
    longint diff, slot, used, lo_edge;
    has = 1'b0;
    r = '0;
    used = (model_cfg.num_bins > MAX_BINS) ? MAX_BINS : longint'(model_cfg.num_bins);
    if (x.action == ACT_ACCUM) begin
      diff = longint'($signed(x.sample)) - longint'($signed(model_cfg.bin_min));
      if (diff >= 0 && model_cfg.bin_size != 0) begin
        slot = diff / longint'(model_cfg.bin_size);
        if (slot < used && tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
      end
    end else begin
      lo_edge = longint'($signed(model_cfg.bin_min)) +
                longint'(x.read_index) * longint'(model_cfg.bin_size);
      has = 1'b1;
      r.bin_number = x.read_index;
      r.lower_edge = lo_edge[EDGE_W-1:0];
      r.bin_count  = tally[x.read_index][OCNT_W-1:0];
      tally[x.read_index] = '0;
    end
  endfunction

  task automatic mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    logic     has;
    ubh_out_t res, w;
    pin_t     p;
    if (rst_n) begin
      if (out_valid) begin
        if (due_reports.size() == 0) begin
          mismatch("unexpected transfer", '0, 64'(out_data.bin_count));
        end else begin
          w = due_reports.pop_front();
          if (out_data.bin_number !== w.bin_number)
            mismatch("bin_number", 64'(w.bin_number), 64'(out_data.bin_number));
          if (out_data.lower_edge !== w.lower_edge)
            mismatch("lower_edge", 64'(w.lower_edge), 64'(out_data.lower_edge));
          if (out_data.bin_count !== w.bin_count)
            mismatch("bin_count", 64'(w.bin_count), 64'(out_data.bin_count));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NUM_BINS: model_cfg.num_bins = cfg_data[NB_W-1:0];
          CFG_BIN_MIN:  model_cfg.bin_min  = cfg_data[SAMPLE_W-1:0];
          CFG_BIN_SIZE: model_cfg.bin_size = cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        p = pinned_reports.pop_front();
        tally_step(in_data, has, res);
        if (has) due_reports.push_back(p.pinned ? p.want : res);
      end
    end
  end

  function automatic ubh_in_t acc(input int s);
    ubh_in_t x;
    x = '0;
    x.action = ACT_ACCUM;
    x.sample = s[SAMPLE_W-1:0];
    return x;
  endfunction

  function automatic ubh_in_t rd(input int idx);
    ubh_in_t x;
    x = '0;
    x.action = ACT_READ;
    x.read_index = idx[IDX_W-1:0];
    return x;
  endfunction

  function automatic ubh_out_t got(input int idx, input longint lo, input int cnt);
    ubh_out_t r;
    r.bin_number = idx[IDX_W-1:0];
    r.lower_edge = lo[EDGE_W-1:0];
    r.bin_count  = cnt[OCNT_W-1:0];
    return r;
  endfunction

  function automatic ubh_in_t pick_item(input ubh_cfg_t c);
    ubh_in_t x;
    longint used, span, lo, s;
    x.action = ($urandom_range(0, 9) < 3) ? ACT_READ : ACT_ACCUM;
    x.sample = SAMPLE_W'($urandom);
    x.read_index = IDX_W'($urandom);
    used = (c.num_bins > MAX_BINS) ? MAX_BINS : longint'(c.num_bins);
    lo = longint'($signed(c.bin_min));
    span = used * longint'(c.bin_size);
    if (x.action == ACT_READ) begin
      if (used != 0 && $urandom_range(0, 4) < 3)
        x.read_index = IDX_W'($urandom_range(0, int'(used - 1)));
    end else if (span > 0) begin
      s = 64'sh7fffffffffffffff;
      case ($urandom_range(0, 7))
        0, 1, 2, 3: s = lo + longint'($urandom) % span;
        4: s = lo + longint'($urandom_range(0, int'(used - 1))) * longint'(c.bin_size);
        5: s = lo + longint'($urandom_range(1, int'(used))) * longint'(c.bin_size) - 1;
        6: s = $urandom_range(0, 1) ? lo + span : lo - 1;
        default: ;
      endcase
      if (s >= -(64'sd1 << 23) && s < (64'sd1 << 23)) x.sample = s[SAMPLE_W-1:0];
    end
    return x;
  endfunction

  task automatic send(input ubh_in_t x, input bit pinned, input ubh_out_t want);
    pinned_reports.push_back('{pinned, want});
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
  endtask

  // accumulate jobs give no transfer, so let the back end finish before touching config
  task automatic drain();
    start <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_cfg(input ubh_cfg_t c);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_NUM_BINS;
    cfg_data <= CFG_DW'(c.num_bins);
    @(posedge clk);
    cfg_addr <= CFG_BIN_MIN;
    cfg_data <= c.bin_min;
    @(posedge clk);
    cfg_addr <= CFG_BIN_SIZE;
    cfg_data <= CFG_DW'(c.bin_size);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    plan_row_t plan [15];
    ubh_cfg_t  settings [8];
    ubh_cfg_t  c;
    bit        gaps;

    // reset config: 255 bins, bin_min 0, bin_size 1.0
    plan = '{
      '{rd(0),   1'b1, got(0, 0, 0)},
      '{rd(255), 1'b1, got(255, 65280, 0)},
      '{acc(0),           1'b0, '0},
      '{acc(255),         1'b0, '0},
      '{acc(256),         1'b0, '0},
      '{acc(-1),          1'b0, '0},
      '{acc(-8388608),    1'b0, '0},
      '{acc(8388607),     1'b0, '0},
      '{acc(254*256 + 10), 1'b0, '0},
      '{acc(255*256),     1'b0, '0},
      '{rd(0),   1'b1, got(0, 0, 2)},
      '{rd(0),   1'b1, got(0, 0, 0)},
      '{rd(1),   1'b1, got(1, 256, 1)},
      '{rd(254), 1'b1, got(254, 65024, 1)},
      '{rd(255), 1'b1, got(255, 65280, 0)}
    };
    settings = '{
      '{9'd256, 24'h000000, 23'd256},
      '{9'd1,   24'h800000, 23'd1},
      '{9'd16,  24'hfffc00, 23'd64},
      '{9'd0,   24'h000000, 23'd256},
      '{9'd511, 24'h000064, 23'd7},
      '{9'd40,  24'h7fffff, 23'h7fffff},
      '{9'd200, 24'h800000, 23'h7fffff},
      '{9'd64,  24'h000000, 23'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send(plan[i].item, plan[i].pinned, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph < 8) begin
        c = settings[ph];
      end else begin
        c.num_bins = NB_W'($urandom_range(1, 300));
        c.bin_min  = (ph == 9) ? 24'($urandom) : 24'($urandom_range(0, 131071) - 65536);
        c.bin_size = SIZE_W'($urandom_range(1, 2048));
      end
      load_cfg(c);
      gaps = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < PER_PHASE; k++) begin
        send(pick_item(c), 1'b0, '0);
        if (gaps && $urandom_range(0, 9) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
    drain();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ubh_pkg.sv
sv/ubh_ram.sv
sv/ubh_front.sv
sv/ubh_queue.sv
sv/ubh_back.sv
sv/uniform_bin_histogram_unit.sv
verif/testbench.sv
